### rtl/core/bcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int NOW_W   = 32;   // width of the sampled time field
  localparam int DELAY_W = 16;   // width of every delay register
  localparam int COUNT_W = 8;    // press counter width
  localparam int CFG_IDX_W = 2;

  typedef logic [DELAY_W-1:0]   delay_t;
  typedef logic [NOW_W-1:0]     now_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [1:0] {
    CLS_OFF       = 2'd0,
    CLS_MOMENTARY = 2'd1,
    CLS_LATCHED   = 2'd2,
    CLS_DOUBLE    = 2'd3
  } class_t;

  // configuration register indexes
  localparam cfg_idx_t REG_DEBOUNCE = 2'd0;
  localparam cfg_idx_t REG_MOMENTARY = 2'd1;
  localparam cfg_idx_t REG_DOUBLE = 2'd2;

  localparam delay_t DEBOUNCE_RST  = 16'd10;
  localparam delay_t MOMENTARY_RST = 16'd500;
  localparam delay_t DOUBLE_RST    = 16'd300;

  localparam count_t COUNT_MAX = '1;

endpackage

### rtl/core/bcc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_in_if
// Sample request channel: pin level and millisecond time.
// ----------------------------------------------------------------------------
interface bcc_in_if;
  import bcc_pkg::*;

  logic valid;
  logic ready;
  logic button_level;
  now_t now_ms;

  modport source (output valid, output button_level, output now_ms, input ready);
  modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface

### rtl/core/bcc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_out_if
// Result request channel: button class.
// ----------------------------------------------------------------------------
interface bcc_out_if;
  import bcc_pkg::*;

  logic   valid;
  logic   ready;
  class_t button_class;

  modport source (output valid, output button_class, input ready);
  modport sink   (input valid, input button_class, output ready);
endinterface

### rtl/core/bcc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bcc_cfg_if;
  import bcc_pkg::*;

  logic     valid;
  logic     ready;
  cfg_idx_t index;
  delay_t   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/button_click_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_classifier
// Debounced push-button classifier: off, momentary, latched, double click.
// ----------------------------------------------------------------------------
// Each sample request (pin level, ms time) yields exactly one class request.
// The sample is captured in an input register, then one pass of
// subtract-and-compare logic against the state registers writes the result
// register. One sample is accepted every cycle unless out_req stalls; the
// result register lets a new sample enter while a finished class is still
// waiting on out_req. The config port is always ready; write it only while
// the block is idle. Time differences wrap modulo 2^TIME_BITS; a press
// counter saturates at its maximum.
module button_click_classifier #(
  parameter int TIME_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  bcc_in_if.sink    in_req,
  bcc_out_if.source out_req,
  bcc_cfg_if.sink   cfg_req
);
  import bcc_pkg::*;

  // bits of the sampled time that survive masking to TIME_BITS
  localparam int KEEP_W = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;

  typedef logic [TIME_BITS-1:0] tm_t;

  // configuration
  delay_t debounce_r, momentary_r, double_r;

  // input stage
  logic s1_valid_r;
  logic s1_level_r;
  now_t s1_now_r;

  // result stage
  logic   out_valid_r;
  class_t out_class_r;

  // classifier state
  logic   stable_level_r, stable_level_nxt;
  logic   lockout_r, lockout_nxt;
  logic   toggle_r, toggle_nxt;
  count_t count_r, count_nxt;
  class_t class_r, class_nxt;
  tm_t    last_edge_r, last_edge_nxt;
  tm_t    win_start_r, win_start_nxt;

  logic s1_adv;
  tm_t  now_t_v;
  tm_t  since_edge_old, since_edge_new, since_win;
  logic is_edge;

  // handshakes
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_req.ready);
  assign in_req.ready  = !s1_valid_r || s1_adv;
  assign cfg_req.ready = 1'b1;
  assign out_req.valid = out_valid_r;
  assign out_req.button_class = out_class_r;

  // configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEBOUNCE_RST;
      momentary_r <= MOMENTARY_RST;
      double_r    <= DOUBLE_RST;
    end else if (cfg_req.valid) begin
      case (cfg_req.index)
        REG_DEBOUNCE:  debounce_r  <= cfg_req.data;
        REG_MOMENTARY: momentary_r <= cfg_req.data;
        REG_DOUBLE:    double_r    <= cfg_req.data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_level_r <= in_req.button_level;
      s1_now_r   <= in_req.now_ms;
    end
  end

  // classification pass
  always_comb begin
    now_t_v = tm_t'(s1_now_r[KEEP_W-1:0]);
    is_edge = (s1_level_r != stable_level_r) && !lockout_r;

    stable_level_nxt = stable_level_r;
    lockout_nxt      = lockout_r;
    toggle_nxt       = toggle_r;
    count_nxt        = count_r;
    class_nxt        = class_r;
    last_edge_nxt    = last_edge_r;
    win_start_nxt    = win_start_r;

    since_edge_old = now_t_v - last_edge_r;

    // edge handling
    if (is_edge) begin
      lockout_nxt   = 1'b1;
      last_edge_nxt = now_t_v;
      if (!s1_level_r) begin
        // press: opens a double-click candidate
        win_start_nxt = last_edge_r;
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + count_t'(1);
        end
        class_nxt = CLS_MOMENTARY;
      end else if (count_r != '0) begin
        class_nxt = CLS_DOUBLE;
      end else if (class_r == CLS_MOMENTARY && since_edge_old < tm_t'(momentary_r)) begin
        class_nxt  = toggle_r ? CLS_OFF : CLS_LATCHED;
        toggle_nxt = !toggle_r;
      end else begin
        class_nxt = CLS_OFF;
      end
    end

    // lockout expiry, measured from the possibly updated edge time
    since_edge_new = now_t_v - last_edge_nxt;
    if (lockout_nxt && since_edge_new > tm_t'(debounce_r)) begin
      lockout_nxt      = 1'b0;
      stable_level_nxt = s1_level_r;
    end

    // double-click window expiry
    since_win = now_t_v - win_start_nxt;
    if (since_win > tm_t'(double_r)) begin
      count_nxt = '0;
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_level_r <= 1'b0;
      lockout_r      <= 1'b0;
      toggle_r       <= 1'b0;
      count_r        <= '0;
      class_r        <= CLS_OFF;
      last_edge_r    <= '0;
      win_start_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (s1_adv) begin
        stable_level_r <= stable_level_nxt;
        lockout_r      <= lockout_nxt;
        toggle_r       <= toggle_nxt;
        count_r        <= count_nxt;
        class_r        <= class_nxt;
        last_edge_r    <= last_edge_nxt;
        win_start_r    <= win_start_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_req.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_class_r <= class_nxt;
    end
  end

endmodule
